/* hdl/cat_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cat_pkg
// Types and constants shared by the copy alias tracker modules.
// ----------------------------------------------------------------------------
package cat_pkg;

    localparam int REG_W     = 8;
    localparam int SIZE_W    = 4;
    localparam int REG_SPACE = 1 << REG_W;

    typedef enum logic [1:0] {
        ACT_USE     = 2'd0,
        ACT_DEFINE  = 2'd1,
        ACT_COPY    = 2'd2,
        ACT_BARRIER = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK,
        ST_LOOK_WAIT,
        ST_SCAN,
        ST_DRAIN,
        ST_WALK,
        ST_WALK_WAIT,
        ST_RECORD,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        RD_LOOK,
        RD_SCAN,
        RD_WALK
    } rd_sel_t;

    typedef struct packed {
        logic    capture;
        logic    look_latch;
        logic    scan_step;
        logic    walk_init;
        logic    walk_step;
        logic    walk_load;
        logic    record;
        logic    clear_all;
        logic    out_load;
        rd_sel_t rd_sel;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    scan_last;
        logic    rec_ok;
        logic    walk_go;
        logic    out_free;
    } status_t;

endpackage
`default_nettype wire

/* hdl/cat_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cat_ctrl
// Sequencer for lookup, table scan, root walk, record, barrier clear and output handoff.
// ----------------------------------------------------------------------------
module cat_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [1:0]       s_action,
    input  wire cat_pkg::status_t status,
    output cat_pkg::cmd_t         cmd
);

    cat_pkg::state_t state_reg;
    cat_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cat_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cat_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (cat_pkg::action_t'(s_action))
                        cat_pkg::ACT_USE:    state_next = cat_pkg::ST_LOOK;
                        cat_pkg::ACT_COPY:   state_next = cat_pkg::ST_LOOK;
                        cat_pkg::ACT_DEFINE: state_next = cat_pkg::ST_SCAN;
                        default:             state_next = cat_pkg::ST_CLEAR;
                    endcase
                end
            end
            cat_pkg::ST_LOOK: state_next = cat_pkg::ST_LOOK_WAIT;
            cat_pkg::ST_LOOK_WAIT: begin
                if (status.action == cat_pkg::ACT_USE) begin
                    state_next = cat_pkg::ST_DONE;
                end else begin
                    state_next = cat_pkg::ST_SCAN;
                end
            end
            cat_pkg::ST_SCAN: begin
                if (status.scan_last) begin
                    state_next = cat_pkg::ST_DRAIN;
                end
            end
            cat_pkg::ST_DRAIN: begin
                if (status.action == cat_pkg::ACT_COPY && status.rec_ok) begin
                    state_next = cat_pkg::ST_WALK;
                end else begin
                    state_next = cat_pkg::ST_DONE;
                end
            end
            cat_pkg::ST_WALK: begin
                if (status.walk_go) begin
                    state_next = cat_pkg::ST_WALK_WAIT;
                end else begin
                    state_next = cat_pkg::ST_RECORD;
                end
            end
            cat_pkg::ST_WALK_WAIT: state_next = cat_pkg::ST_WALK;
            cat_pkg::ST_RECORD:    state_next = cat_pkg::ST_DONE;
            cat_pkg::ST_CLEAR:     state_next = cat_pkg::ST_DONE;
            cat_pkg::ST_DONE: begin
                if (status.out_free) begin
                    state_next = cat_pkg::ST_IDLE;
                end
            end
            default: state_next = cat_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        cmd.rd_sel = cat_pkg::RD_SCAN;
        case (state_reg)
            cat_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            cat_pkg::ST_LOOK:      cmd.rd_sel = cat_pkg::RD_LOOK;
            cat_pkg::ST_LOOK_WAIT: cmd.look_latch = 1'b1;
            cat_pkg::ST_SCAN: begin
                cmd.rd_sel    = cat_pkg::RD_SCAN;
                cmd.scan_step = 1'b1;
            end
            cat_pkg::ST_DRAIN:     cmd.walk_init = 1'b1;
            cat_pkg::ST_WALK: begin
                cmd.rd_sel    = cat_pkg::RD_WALK;
                cmd.walk_step = status.walk_go;
            end
            cat_pkg::ST_WALK_WAIT: cmd.walk_load = 1'b1;
            cat_pkg::ST_RECORD:    cmd.record = 1'b1;
            cat_pkg::ST_CLEAR:     cmd.clear_all = 1'b1;
            cat_pkg::ST_DONE:      cmd.out_load = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

/* hdl/cat_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cat_dpath
// Alias table (root memory plus valid flops), item registers, scan index,
// root walk pointer and output register.
// ----------------------------------------------------------------------------
module cat_dpath #(
    parameter int NUM_REGS = 256
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire cat_pkg::cmd_t               cmd,
    output cat_pkg::status_t                 status,
    input  wire logic [1:0]                  s_action,
    input  wire logic [cat_pkg::REG_W-1:0]   s_reg_id,
    input  wire logic [cat_pkg::REG_W-1:0]   s_src_id,
    input  wire logic                        s_dst_float,
    input  wire logic                        s_src_float,
    input  wire logic [cat_pkg::SIZE_W-1:0]  s_dst_size,
    input  wire logic [cat_pkg::SIZE_W-1:0]  s_src_size,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [cat_pkg::REG_W-1:0]        m_reg_out,
    output logic                             m_replaced,
    output logic                             m_any_changed
);

    localparam int TBL_DEPTH = (NUM_REGS < cat_pkg::REG_SPACE) ? NUM_REGS : cat_pkg::REG_SPACE;
    localparam int IDX_W     = $clog2(TBL_DEPTH);
    localparam int STEP_W    = $clog2(NUM_REGS + 1);

    function automatic logic in_tbl(input logic [cat_pkg::REG_W-1:0] r);
        return (32'(r) < NUM_REGS);
    endfunction

    logic [cat_pkg::REG_W-1:0] root_mem [TBL_DEPTH];
    logic [TBL_DEPTH-1:0]      valid_reg;
    logic [cat_pkg::REG_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]          rd_addr;

    cat_pkg::action_t          action_reg;
    logic [cat_pkg::REG_W-1:0] dst_reg;
    logic [cat_pkg::REG_W-1:0] src_reg;
    logic                      rec_ok_reg;
    logic [cat_pkg::REG_W-1:0] result_reg;
    logic                      hit_reg;
    logic                      changed_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [IDX_W-1:0]          idx_d_reg;
    logic                      cmp_pend_reg;
    logic [cat_pkg::REG_W-1:0] root_reg;
    logic [STEP_W-1:0]         steps_reg;
    logic                      m_valid_reg;

    logic [cat_pkg::REG_W-1:0] look_id;
    logic                      look_hit;
    logic                      own_clr;
    logic                      cmp_hit;
    logic                      rec_do;

    assign look_id  = (action_reg == cat_pkg::ACT_USE) ? dst_reg : src_reg;
    assign look_hit = in_tbl(look_id) && valid_reg[look_id[IDX_W-1:0]];
    assign own_clr  = cmd.scan_step && (idx_reg == '0) && in_tbl(dst_reg);
    assign cmp_hit  = cmp_pend_reg && valid_reg[idx_d_reg] && (rd_data_reg == dst_reg);
    assign rec_do   = cmd.record && (root_reg != dst_reg) && in_tbl(dst_reg);

    always_comb begin
        case (cmd.rd_sel)
            cat_pkg::RD_LOOK: rd_addr = look_id[IDX_W-1:0];
            cat_pkg::RD_WALK: rd_addr = root_reg[IDX_W-1:0];
            default:          rd_addr = idx_reg;
        endcase
    end

    // root memory
    always_ff @(posedge aclk) begin
        rd_data_reg <= root_mem[rd_addr];
        if (rec_do) begin
            root_mem[dst_reg[IDX_W-1:0]] <= root_reg;
        end
    end

    // valid marks
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_all) begin
            valid_reg <= '0;
        end else begin
            if (own_clr) begin
                valid_reg[dst_reg[IDX_W-1:0]] <= 1'b0;
            end
            if (cmp_hit) begin
                valid_reg[idx_d_reg] <= 1'b0;
            end
            if (rec_do) begin
                valid_reg[dst_reg[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    // item registers, scan and walk
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= cat_pkg::action_t'(s_action);
            dst_reg    <= s_reg_id;
            src_reg    <= s_src_id;
            rec_ok_reg <= !s_dst_float && !s_src_float && (s_dst_size == s_src_size);
            result_reg <= s_reg_id;
            hit_reg    <= 1'b0;
            idx_reg    <= '0;
        end
        if (cmd.look_latch) begin
            hit_reg    <= look_hit;
            result_reg <= look_hit ? rd_data_reg : look_id;
        end
        if (cmd.scan_step) begin
            idx_reg   <= idx_reg + 1'b1;
            idx_d_reg <= idx_reg;
        end
        if (cmd.walk_init) begin
            root_reg  <= result_reg;
            steps_reg <= '0;
        end
        if (cmd.walk_step) begin
            steps_reg <= steps_reg + 1'b1;
        end
        if (cmd.walk_load) begin
            root_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_pend_reg <= 1'b0;
            changed_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            cmp_pend_reg <= cmd.scan_step;
            if (cmd.look_latch && look_hit) begin
                changed_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_reg_out     <= result_reg;
            m_replaced    <= hit_reg;
            m_any_changed <= changed_reg;
        end
    end

    assign m_valid = m_valid_reg;

    always_comb begin
        status.action    = action_reg;
        status.scan_last = (idx_reg == IDX_W'(TBL_DEPTH - 1));
        status.rec_ok    = rec_ok_reg;
        status.walk_go   = (32'(steps_reg) < NUM_REGS) && in_tbl(root_reg)
                           && valid_reg[root_reg[IDX_W-1:0]];
        status.out_free  = !m_valid_reg || m_ready;
    end

endmodule
`default_nettype wire

/* hdl/copy_alias_tracker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// copy_alias_tracker
// Alias table for local copy propagation over register numbers.
//
//   channel  dir  handshake         payload
//   s_       in   s_valid/s_ready   action reg_id src_id dst_float src_float
//                                   dst_size src_size
//   m_       out  m_valid/m_ready   reg_out replaced any_changed
//
// One item at a time. Defines and copies scan min(NUM_REGS, 256) entries of
// the root memory through its single read port, one entry a cycle; a copy
// that can be recorded then takes walk steps along the root chain.
// Reset clears the valid flops at once; no clearing pass.
// A result held on m_ stalls only the handoff of the next finished item.
// ----------------------------------------------------------------------------
module copy_alias_tracker #(
    parameter int NUM_REGS = 256
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_action,
    input  wire logic [cat_pkg::REG_W-1:0]   s_reg_id,
    input  wire logic [cat_pkg::REG_W-1:0]   s_src_id,
    input  wire logic                        s_dst_float,
    input  wire logic                        s_src_float,
    input  wire logic [cat_pkg::SIZE_W-1:0]  s_dst_size,
    input  wire logic [cat_pkg::SIZE_W-1:0]  s_src_size,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [cat_pkg::REG_W-1:0]        m_reg_out,
    output logic                             m_replaced,
    output logic                             m_any_changed
);

    cat_pkg::cmd_t    cmd;
    cat_pkg::status_t status;

    cat_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .status   (status),
        .cmd      (cmd)
    );

    cat_dpath #(
        .NUM_REGS (NUM_REGS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_action      (s_action),
        .s_reg_id      (s_reg_id),
        .s_src_id      (s_src_id),
        .s_dst_float   (s_dst_float),
        .s_src_float   (s_src_float),
        .s_dst_size    (s_dst_size),
        .s_src_size    (s_src_size),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_reg_out     (m_reg_out),
        .m_replaced    (m_replaced),
        .m_any_changed (m_any_changed)
    );

endmodule
`default_nettype wire

/* tb/sv/copy_alias_tracker_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// copy_alias_tracker_tb
// Self-checking bench for the copy alias tracker. A queue of items, directed
// first and then random, mostly over small register pools, feeds a clocked driver.
// Every accepted item is run through a local alias table model. A clocked
// monitor compares each result with the oldest prediction. Both sides idle
// and stall at random.
// ----------------------------------------------------------------------------
module copy_alias_tracker_tb;

    localparam int TBL_DEPTH   = cat_pkg::REG_SPACE;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RAND_ITEMS  = 750;
    localparam int DRAIN_AT    = 400;
    localparam int TAIL_CYCLES = 1000;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        cat_pkg::action_t           action;
        logic [cat_pkg::REG_W-1:0]  reg_id;
        logic [cat_pkg::REG_W-1:0]  src_id;
        logic                       dst_float;
        logic                       src_float;
        logic [cat_pkg::SIZE_W-1:0] dst_size;
        logic [cat_pkg::SIZE_W-1:0] src_size;
        int                         hold_off;
        bit                         wait_drain;
    } alias_item_t;

    typedef struct {
        logic [cat_pkg::REG_W-1:0] reg_out;
        logic                      replaced;
        logic                      any_changed;
    } alias_result_t;

    logic                       aclk          = 1'b0;
    logic                       aresetn       = 1'b0;
    logic                       s_valid       = 1'b0;
    logic                       s_ready;
    logic [1:0]                 s_action      = '0;
    logic [cat_pkg::REG_W-1:0]  s_reg_id      = '0;
    logic [cat_pkg::REG_W-1:0]  s_src_id      = '0;
    logic                       s_dst_float   = 1'b0;
    logic                       s_src_float   = 1'b0;
    logic [cat_pkg::SIZE_W-1:0] s_dst_size    = '0;
    logic [cat_pkg::SIZE_W-1:0] s_src_size    = '0;
    logic                       m_valid;
    logic                       m_ready       = 1'b0;
    logic [cat_pkg::REG_W-1:0]  m_reg_out;
    logic                       m_replaced;
    logic                       m_any_changed;

    alias_item_t   pending_items[$];
    alias_result_t expected_results[$];
    alias_item_t   tx_item;

    logic                      tbl_valid [TBL_DEPTH] = '{default: 1'b0};
    logic [cat_pkg::REG_W-1:0] tbl_root  [TBL_DEPTH] = '{default: '0};
    logic                      tbl_changed = 1'b0;

    int  tx_idle;
    int  tx_since;
    int  rx_wait;
    int  rx_draw;
    int  checked_cnt = 0;
    int  err_cnt     = 0;
    int  cycle_cnt   = 0;

    copy_alias_tracker #(
        .NUM_REGS(TBL_DEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_reg_id     (s_reg_id),
        .s_src_id     (s_src_id),
        .s_dst_float  (s_dst_float),
        .s_src_float  (s_src_float),
        .s_dst_size   (s_dst_size),
        .s_src_size   (s_src_size),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_reg_out    (m_reg_out),
        .m_replaced   (m_replaced),
        .m_any_changed(m_any_changed)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic [cat_pkg::REG_W-1:0] resolve_operand(
        input logic [cat_pkg::REG_W-1:0] r, output logic hit);
        hit = tbl_valid[r];
        if (hit) begin
            tbl_changed = 1'b1;
            return tbl_root[r];
        end
        return r;
    endfunction

    function automatic void kill_aliases(input logic [cat_pkg::REG_W-1:0] d);
        tbl_valid[d] = 1'b0;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            if (tbl_valid[i] && tbl_root[i] == d)
                tbl_valid[i] = 1'b0;
        end
    endfunction

    function automatic alias_result_t predict_alias(input alias_item_t it);
        alias_result_t             res;
        logic [cat_pkg::REG_W-1:0] root;
        logic                      hit;
        int                        steps;
        res.reg_out = it.reg_id;
        hit = 1'b0;
        case (it.action)
            cat_pkg::ACT_USE: begin
                res.reg_out = resolve_operand(it.reg_id, hit);
            end
            cat_pkg::ACT_DEFINE: begin
                kill_aliases(it.reg_id);
            end
            cat_pkg::ACT_COPY: begin
                res.reg_out = resolve_operand(it.src_id, hit);
                kill_aliases(it.reg_id);
                if (!it.dst_float && !it.src_float && it.dst_size == it.src_size) begin
                    root = res.reg_out;
                    steps = 0;
                    while (steps < TBL_DEPTH && tbl_valid[root]) begin
                        root = tbl_root[root];
                        steps++;
                    end
                    if (root != it.reg_id) begin
                        tbl_valid[it.reg_id] = 1'b1;
                        tbl_root[it.reg_id] = root;
                    end
                end
            end
            default: begin
                foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
            end
        endcase
        res.replaced = hit;
        res.any_changed = tbl_changed;
        return res;
    endfunction

    function automatic alias_item_t make_item(input cat_pkg::action_t act, input int rg,
                                              input int sr, input int df, input int sf,
                                              input int dsz, input int ssz);
        alias_item_t it;
        it.action = act;
        it.reg_id = rg[cat_pkg::REG_W-1:0];
        it.src_id = sr[cat_pkg::REG_W-1:0];
        it.dst_float = df[0];
        it.src_float = sf[0];
        it.dst_size = dsz[cat_pkg::SIZE_W-1:0];
        it.src_size = ssz[cat_pkg::SIZE_W-1:0];
        it.hold_off = $urandom_range(0, 11);
        it.wait_drain = 1'b0;
        return it;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_since <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(predict_alias(tx_item));
            if (!s_valid || s_ready) begin
                tx_idle = (s_valid && s_ready) ? 0 : tx_since;
                if (pending_items.size() != 0 && tx_idle >= pending_items[0].hold_off &&
                    (!pending_items[0].wait_drain || expected_results.size() == 0)) begin
                    tx_item = pending_items.pop_front();
                    s_valid     <= 1'b1;
                    s_action    <= tx_item.action;
                    s_reg_id    <= tx_item.reg_id;
                    s_src_id    <= tx_item.src_id;
                    s_dst_float <= tx_item.dst_float;
                    s_src_float <= tx_item.src_float;
                    s_dst_size  <= tx_item.dst_size;
                    s_src_size  <= tx_item.src_size;
                    tx_since    <= 0;
                end else begin
                    s_valid  <= 1'b0;
                    tx_since <= tx_idle + 1;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("unexpected item: reg_out=%0d replaced=%0b any_changed=%0b",
                             m_reg_out, m_replaced, m_any_changed);
            end else begin
                alias_result_t exp_res;
                exp_res = expected_results.pop_front();
                if (m_reg_out !== exp_res.reg_out || m_replaced !== exp_res.replaced ||
                    m_any_changed !== exp_res.any_changed) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("mismatch at item %0d: expected %0d/%0b/%0b actual %0d/%0b/%0b",
                                 checked_cnt, exp_res.reg_out, exp_res.replaced,
                                 exp_res.any_changed, m_reg_out, m_replaced, m_any_changed);
                end
            end
            checked_cnt++;
            rx_draw = ((checked_cnt / 40) % 3 == 0) ? 0 : $urandom_range(0, 11);
            if (rx_draw == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                rx_wait <= rx_draw - 1;
            end
        end else if (!m_ready && m_valid) begin
            if (rx_wait == 0)
                m_ready <= 1'b1;
            else
                rx_wait <= rx_wait - 1;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("copy_alias_tracker_tb failed");
            $finish;
        end
    end

    initial begin
        alias_item_t it;
        int          pool_base;
        int          pick;
        int          sz;
        int          rsel;
        int          total_items;

        // directed
        pending_items.push_back(make_item(cat_pkg::ACT_USE, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(cat_pkg::ACT_USE, 255, 255, 1, 1, 15, 15));
        pending_items.push_back(make_item(cat_pkg::ACT_COPY, 10, 20, 0, 0, 4, 4));
        pending_items.push_back(make_item(cat_pkg::ACT_USE, 10, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(cat_pkg::ACT_COPY, 11, 10, 0, 0, 8, 8));
        pending_items.push_back(make_item(cat_pkg::ACT_USE, 11, 3, 0, 0, 0, 0));
        pending_items.push_back(make_item(cat_pkg::ACT_DEFINE, 20, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(cat_pkg::ACT_USE, 10, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(cat_pkg::ACT_COPY, 12, 13, 1, 0, 4, 4));
        pending_items.push_back(make_item(cat_pkg::ACT_USE, 12, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(cat_pkg::ACT_COPY, 12, 13, 0, 1, 15, 15));
        pending_items.push_back(make_item(cat_pkg::ACT_COPY, 12, 13, 0, 0, 0, 15));
        pending_items.push_back(make_item(cat_pkg::ACT_COPY, 13, 13, 0, 0, 0, 0));
        pending_items.push_back(make_item(cat_pkg::ACT_COPY, 0, 255, 0, 0, 15, 15));
        pending_items.push_back(make_item(cat_pkg::ACT_COPY, 255, 0, 0, 0, 15, 15));
        pending_items.push_back(make_item(cat_pkg::ACT_COPY, 1, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(cat_pkg::ACT_USE, 1, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(cat_pkg::ACT_BARRIER, 200, 77, 1, 0, 9, 6));
        pending_items.push_back(make_item(cat_pkg::ACT_USE, 1, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(cat_pkg::ACT_DEFINE, 255, 255, 1, 1, 15, 15));
        pending_items.push_back(make_item(cat_pkg::ACT_COPY, 5, 6, 1, 1, 2, 2));
        pending_items.push_back(make_item(cat_pkg::ACT_COPY, 5, 6, 0, 0, 2, 2));
        pending_items.push_back(make_item(cat_pkg::ACT_DEFINE, 5, 6, 0, 0, 0, 0));
        pending_items.push_back(make_item(cat_pkg::ACT_USE, 5, 0, 0, 0, 0, 0));

        // random, mostly over a small sliding register pool
        pool_base = 0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 50 == 0)
                pool_base = $urandom_range(0, 244);
            it = make_item(cat_pkg::ACT_USE, $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 1), $urandom_range(0, 1),
                           $urandom_range(0, 15), $urandom_range(0, 15));
            if ($urandom_range(0, 3) != 0) begin
                rsel = pool_base + $urandom_range(0, 11);
                it.reg_id = rsel[cat_pkg::REG_W-1:0];
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                it.action = cat_pkg::ACT_USE;
            end else if (pick < 55) begin
                it.action = cat_pkg::ACT_DEFINE;
            end else if (pick < 96) begin
                it.action = cat_pkg::ACT_COPY;
                if ($urandom_range(0, 3) != 0) begin
                    rsel = pool_base + $urandom_range(0, 11);
                    it.src_id = rsel[cat_pkg::REG_W-1:0];
                end
                if ($urandom_range(0, 3) != 0) begin
                    sz = $urandom_range(0, 15);
                    it.dst_float = 1'b0;
                    it.src_float = 1'b0;
                    it.dst_size = sz[cat_pkg::SIZE_W-1:0];
                    it.src_size = sz[cat_pkg::SIZE_W-1:0];
                end
            end else begin
                it.action = cat_pkg::ACT_BARRIER;
            end
            if ((n / 40) % 3 == 1)
                it.hold_off = 0;
            it.wait_drain = (n == DRAIN_AT);
            pending_items.push_back(it);
        end
        total_items = pending_items.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (checked_cnt < total_items)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (err_cnt == 0 && expected_results.size() == 0 && checked_cnt == total_items)
            $display("copy_alias_tracker_tb passed");
        else
            $display("copy_alias_tracker_tb failed");
        $finish;
    end

endmodule

/* files.f */
hdl/cat_pkg.sv
hdl/cat_ctrl.sv
hdl/cat_dpath.sv
hdl/copy_alias_tracker.sv
tb/sv/copy_alias_tracker_tb.sv
